// ===== hdl/gcsp_pkg.sv =====
// Package for the GPU control/status port: codes, status masks, the GP0
// packet length table, the display resolution tables and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcsp_pkg;

	// Access kinds carried in s_tuser
	typedef enum logic [2:0] {
		KIND_GP0_WRITE = 3'd0,
		KIND_GP1_WRITE = 3'd1,
		KIND_GP0_READ  = 3'd2,
		KIND_GP1_READ  = 3'd3,
		KIND_FIELD     = 3'd4
	} kind_t;

	// GP1 command codes (top byte of the written word)
	localparam logic [7:0] GP1_RESET      = 8'h00;
	localparam logic [7:0] GP1_CMD_RST_A  = 8'h01;
	localparam logic [7:0] GP1_CMD_RST_B  = 8'h02;
	localparam logic [7:0] GP1_DISP_EN    = 8'h03;
	localparam logic [7:0] GP1_DMA_DIR    = 8'h04;
	localparam logic [7:0] GP1_DISP_START = 8'h05;
	localparam logic [7:0] GP1_HRANGE     = 8'h06;
	localparam logic [7:0] GP1_VRANGE     = 8'h07;
	localparam logic [7:0] GP1_DISP_MODE  = 8'h08;
	localparam logic [7:0] GP1_MODE_EXT   = 8'h09;
	localparam logic [7:0] GP1_INFO       = 8'h10;

	// Info query selectors (low half of the GP1 info word)
	localparam logic [15:0] INFO_SEL_AREA_TL0 = 16'd0;
	localparam logic [15:0] INFO_SEL_AREA_TL1 = 16'd1;
	localparam logic [15:0] INFO_SEL_TEX_WIN  = 16'd2;
	localparam logic [15:0] INFO_SEL_AREA_TL  = 16'd3;
	localparam logic [15:0] INFO_SEL_AREA_BR  = 16'd4;
	localparam logic [15:0] INFO_SEL_OFFSET   = 16'd5;
	localparam logic [15:0] INFO_SEL_OFFSET2  = 16'd6;
	localparam logic [15:0] INFO_SEL_VERSION  = 16'd7;

	// DMA direction word that also aborts the packet in progress
	localparam logic [31:0] DMA_OFF_WORD = 32'h0400_0000;

	// Configuration register indexes
	localparam logic [2:0] CFG_DRAW_LEFT   = 3'd0;
	localparam logic [2:0] CFG_DRAW_TOP    = 3'd1;
	localparam logic [2:0] CFG_DRAW_RIGHT  = 3'd2;
	localparam logic [2:0] CFG_DRAW_BOTTOM = 3'd3;
	localparam logic [2:0] CFG_OFFSET_X    = 3'd4;
	localparam logic [2:0] CFG_OFFSET_Y    = 3'd5;

	// Status word masks
	localparam logic [31:0] STATUS_RESET     = 32'h1480_2000;
	localparam logic [31:0] STATUS_FORCE_SET = 32'h1c00_0000;
	localparam logic [31:0] STATUS_FORCE_CLR = 32'h0048_0000;
	localparam logic [31:0] STATUS_LACE      = 32'h8000_0000;
	localparam logic [31:0] STATUS_BUSY_BITS = 32'h1400_0000;
	localparam logic [31:0] STATUS_CMD_READY = 32'h0800_0000;
	localparam logic [31:0] STATUS_DISP_OFF  = 32'h0080_0000;
	localparam logic [31:0] STATUS_DMA_DIR   = 32'h6000_0000;
	localparam logic [31:0] STATUS_MODE      = 32'h007f_0000;

	// Drawing area reset values
	localparam logic [10:0] DRAW_RIGHT_RESET  = 11'd256;
	localparam logic [10:0] DRAW_BOTTOM_RESET = 11'd240;

	// Info query answer for the GPU version selector
	localparam logic [31:0] INFO_VERSION = 32'd2;

	// Control from the register block to the packet framer
	typedef struct packed {
		logic       write;   // GP0 word taken this cycle
		logic       abort;   // drop the packet in progress
		logic [7:0] opcode;  // top byte of the GP0 word
	} frame_ctl_t;

	// Framer answer for the current GP0 word
	typedef struct packed {
		logic [3:0] index;
		logic       complete;
	} frame_res_t;

	// Words that follow a GP0 header, by opcode
	function automatic logic [3:0] pkt_len(input logic [7:0] op);
		logic [3:0] len;
		len = 4'd0;
		unique case (op[7:2])
			6'h00: len = (op == 8'h02) ? 4'd2 : 4'd0;
			6'h08: len = 4'd3;
			6'h09: len = 4'd6;
			6'h0a: len = 4'd4;
			6'h0b: len = 4'd8;
			6'h0c: len = 4'd5;
			6'h0d: len = 4'd8;
			6'h0e: len = 4'd7;
			6'h0f: len = 4'd11;
			6'h10: len = 4'd2;
			6'h12, 6'h13, 6'h14: len = 4'd3;
			6'h16, 6'h17: len = 4'd4;
			6'h18: len = 4'd2;
			6'h19: len = 4'd3;
			6'h1a, 6'h1c, 6'h1e: len = 4'd1;
			6'h1b, 6'h1d, 6'h1f: len = 4'd2;
			6'h20: len = (op == 8'h80) ? 4'd3 : 4'd0;
			6'h28: len = (op == 8'ha0) ? 4'd2 : 4'd0;
			6'h30: len = (op == 8'hc0) ? 4'd2 : 4'd0;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	// Horizontal resolution by status bits 18:16
	function automatic logic [9:0] hres(input logic [2:0] sel);
		logic [9:0] w;
		unique case (sel)
			3'd0: w = 10'd256;
			3'd1: w = 10'd368;
			3'd2: w = 10'd320;
			3'd3: w = 10'd384;
			3'd4, 3'd5: w = 10'd512;
			3'd6, 3'd7: w = 10'd640;
		endcase
		return w;
	endfunction

	// Vertical resolution by status bits 20:19
	function automatic logic [8:0] vres(input logic [1:0] sel);
		logic [8:0] h;
		unique case (sel)
			2'd0: h = 9'd240;
			2'd1: h = 9'd480;
			2'd2: h = 9'd256;
			2'd3: h = 9'd480;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/gcsp_framer.sv =====
// GP0 packet framer: counts the words of a command packet and tags each one
// with its position and an end-of-packet flag. Depends on gcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcsp_framer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gcsp_pkg::frame_ctl_t  ctl,
	output gcsp_pkg::frame_res_t       res
);

	logic [3:0] remain_q, position_q;
	logic [3:0] remain_d, position_d;

	// Next count: a header loads the length, a body word counts down, an abort clears it
	always_comb begin
		remain_d   = remain_q;
		position_d = position_q;
		res.index  = 4'd0;
		if (ctl.write) begin
			if (remain_q != 4'd0) begin
				remain_d   = remain_q - 4'd1;
				res.index  = position_q;
				position_d = position_q + 4'd1;
			end else begin
				remain_d   = gcsp_pkg::pkt_len(ctl.opcode);
				position_d = 4'd1;
			end
		end else if (ctl.abort) begin
			remain_d = 4'd0;
		end
		res.complete = ctl.write && (remain_d == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= 4'd0;
			position_q <= 4'd0;
		end else begin
			remain_q   <= remain_d;
			position_q <= position_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/gcsp_ctrl_regs.sv =====
// GPU control registers: status word, info latch, display start, drawing
// area configuration and the GP1 command decode. Depends on gcsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcsp_ctrl_regs (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [2:0]           kind,
	input  wire logic [31:0]          word,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [10:0]          cfg_data,
	output gcsp_pkg::frame_ctl_t      frame_ctl,
	output logic      [31:0]          read_word,
	output logic      [9:0]           display_x,
	output logic      [9:0]           display_y,
	output logic      [9:0]           display_width,
	output logic      [8:0]           display_height,
	output logic                      pal_mode
);

	// Horizontal/vertical range and the extra mode flags are taken by the
	// hardware but feed no output here, so they are not stored.
	logic [31:0] status_q, status_d;
	logic [31:0] info_q, info_d;
	logic [9:0]  start_x_q, start_x_d, start_y_q, start_y_d;
	logic        pal_q, pal_d;
	logic [9:0]  left_q, top_q;
	logic [10:0] right_q, bottom_q, offx_q, offy_q;
	logic        soft_reset;
	logic [7:0]  cmd;
	logic [31:0] right_m1, bottom_m1;
	gcsp_pkg::kind_t kind_e;

	assign cmd    = word[31:24];
	assign kind_e = gcsp_pkg::kind_t'(kind);

	// Drawing area edges minus one, wrapping when an edge is zero
	assign right_m1  = {21'd0, right_q} - 32'd1;
	assign bottom_m1 = {21'd0, bottom_q} - 32'd1;

	// Access decode and next state
	always_comb begin
		status_d   = status_q;
		info_d     = info_q;
		start_x_d  = start_x_q;
		start_y_d  = start_y_q;
		pal_d      = pal_q;
		soft_reset = 1'b0;
		read_word  = 32'd0;
		frame_ctl.write  = 1'b0;
		frame_ctl.abort  = 1'b0;
		frame_ctl.opcode = cmd;
		if (step) begin
			unique case (kind_e)
				gcsp_pkg::KIND_GP0_WRITE: begin
					frame_ctl.write = 1'b1;
					status_d = status_q | gcsp_pkg::STATUS_BUSY_BITS;
				end
				gcsp_pkg::KIND_GP1_WRITE: begin
					unique case (cmd)
						gcsp_pkg::GP1_RESET: begin
							soft_reset = 1'b1;
							status_d   = gcsp_pkg::STATUS_RESET;
						end
						gcsp_pkg::GP1_CMD_RST_A, gcsp_pkg::GP1_CMD_RST_B: begin
							status_d = status_q & ~gcsp_pkg::STATUS_CMD_READY;
							frame_ctl.abort = 1'b1;
						end
						gcsp_pkg::GP1_DISP_EN: begin
							status_d = (status_q & ~gcsp_pkg::STATUS_DISP_OFF)
								| {8'd0, word[0], 23'd0};
						end
						gcsp_pkg::GP1_DMA_DIR: begin
							frame_ctl.abort = (word == gcsp_pkg::DMA_OFF_WORD);
							status_d = (status_q & ~gcsp_pkg::STATUS_DMA_DIR)
								| {1'b0, word[1:0], 29'd0};
						end
						gcsp_pkg::GP1_DISP_START: begin
							start_x_d = word[9:0];
							start_y_d = word[19:10];
						end
						gcsp_pkg::GP1_DISP_MODE: begin
							status_d = (status_q & ~gcsp_pkg::STATUS_MODE)
								| {9'd0, word[5:0], word[6], 16'd0};
							pal_d = word[3];
						end
						gcsp_pkg::GP1_INFO: begin
							unique case (word[15:0])
								gcsp_pkg::INFO_SEL_AREA_TL0, gcsp_pkg::INFO_SEL_AREA_TL1,
								gcsp_pkg::INFO_SEL_AREA_TL:
									info_d = {12'd0, top_q, left_q};
								gcsp_pkg::INFO_SEL_AREA_BR:
									info_d = (bottom_m1 << 10) | right_m1;
								gcsp_pkg::INFO_SEL_OFFSET, gcsp_pkg::INFO_SEL_OFFSET2:
									info_d = {10'd0, offy_q, offx_q};
								gcsp_pkg::INFO_SEL_VERSION: info_d = gcsp_pkg::INFO_VERSION;
								default: info_d = 32'd0;
							endcase
						end
						default: ;
					endcase
				end
				gcsp_pkg::KIND_GP0_READ: begin
					status_d  = status_q | gcsp_pkg::STATUS_BUSY_BITS;
					read_word = info_q;
				end
				gcsp_pkg::KIND_GP1_READ: begin
					read_word = (status_q | gcsp_pkg::STATUS_FORCE_SET)
						& ~gcsp_pkg::STATUS_FORCE_CLR;
				end
				gcsp_pkg::KIND_FIELD: begin
					status_d = status_q ^ gcsp_pkg::STATUS_LACE;
				end
				default: ;
			endcase
		end
	end

	// Display fields as they stand after this access; the mode bits of the
	// status word always select the resolution
	assign display_x      = start_x_d;
	assign display_y      = start_y_d;
	assign display_width  = gcsp_pkg::hres(status_d[18:16]);
	assign display_height = gcsp_pkg::vres(status_d[20:19]);
	assign pal_mode       = pal_d;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= gcsp_pkg::STATUS_RESET;
			info_q    <= 32'd0;
			start_x_q <= 10'd0;
			start_y_q <= 10'd0;
			pal_q     <= 1'b0;
		end else begin
			status_q  <= status_d;
			info_q    <= info_d;
			start_x_q <= start_x_d;
			start_y_q <= start_y_d;
			pal_q     <= pal_d;
		end
	end

	// Drawing area configuration; GP1 reset restores the far edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 10'd0;
			top_q    <= 10'd0;
			right_q  <= gcsp_pkg::DRAW_RIGHT_RESET;
			bottom_q <= gcsp_pkg::DRAW_BOTTOM_RESET;
			offx_q   <= 11'd0;
			offy_q   <= 11'd0;
		end else if (soft_reset) begin
			right_q  <= gcsp_pkg::DRAW_RIGHT_RESET;
			bottom_q <= gcsp_pkg::DRAW_BOTTOM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcsp_pkg::CFG_DRAW_LEFT:   left_q   <= cfg_data[9:0];
				gcsp_pkg::CFG_DRAW_TOP:    top_q    <= cfg_data[9:0];
				gcsp_pkg::CFG_DRAW_RIGHT:  right_q  <= cfg_data;
				gcsp_pkg::CFG_DRAW_BOTTOM: bottom_q <= cfg_data;
				gcsp_pkg::CFG_OFFSET_X:    offx_q   <= cfg_data;
				gcsp_pkg::CFG_OFFSET_Y:    offy_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/gpu_control_status_port.sv =====
// Top level of the GPU control/status port: input register, register block,
// GP0 packet framer and result register. Depends on gcsp_pkg,
// gcsp_ctrl_regs and gcsp_framer.
`timescale 1ns / 1ps
`default_nettype none

// One bus access or field tick per input transfer, one result per access.
// An access is held in the input register, decoded there, and its result is
// captured in the output register; one access a cycle when the output side
// takes every result. The state update for an access happens in the same
// cycle as its decode, so the next access sees it at once. Configuration
// writes take effect at the next edge.
module gpu_control_status_port (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] word
	input  wire logic [2:0]  s_tuser,   // [2:0] kind
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] read_word, [35:32] packet_word_index, [45:36] display_x,
	// [55:46] display_y, [65:56] display_width, [74:66] display_height,
	// [75] pal_mode, [79:76] zero
	output logic      [79:0] m_tdata,
	output logic             m_tuser,   // [0] packet_word_valid
	output logic             m_tlast,   // packet_complete
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);

	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [31:0] word_s1;
	logic        advance, step;

	gcsp_pkg::frame_ctl_t frame_ctl;
	gcsp_pkg::frame_res_t frame_res;

	logic [31:0] read_word;
	logic [9:0]  display_x, display_y, display_width;
	logic [8:0]  display_height;
	logic        pal_mode;

	// Output register free, or being emptied this cycle
	assign advance  = !m_tvalid || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			word_s1 <= s_tdata;
		end
	end

	gcsp_ctrl_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.kind           (kind_s1),
		.word           (word_s1),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.frame_ctl      (frame_ctl),
		.read_word      (read_word),
		.display_x      (display_x),
		.display_y      (display_y),
		.display_width  (display_width),
		.display_height (display_height),
		.pal_mode       (pal_mode)
	);

	gcsp_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (frame_ctl),
		.res    (frame_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= {4'd0, pal_mode, display_height, display_width, display_y,
				display_x, frame_res.index, read_word};
			m_tuser <= frame_ctl.write;
			m_tlast <= frame_res.complete;
		end
	end

endmodule

`default_nettype wire
